// ===== rtl/q16fp_pkg.sv =====
package q16fp_pkg;

   // operation codes carried in tuser
   typedef enum logic [1:0] {
      FUNC_MUL  = 2'd0,
      FUNC_DIV  = 2'd1,
      FUNC_F2FX = 2'd2,
      FUNC_ABS  = 2'd3
   } func_type;

   // status codes returned in tuser
   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_DIVZ = 2'd1,
      ERR_OVF  = 2'd2
   } err_type;

   // control that rides along the cell chain with each word
   typedef struct packed {
      logic     valid;
      func_type func;
      logic     neg;
      err_type  err;
   } ctrl_type;

   // IEEE single field layout
   localparam int MANT_BITS = 23;
   localparam int EXP_BIAS_SHIFT = 150;

endpackage

// ===== rtl/q16fp_cell.sv =====
module q16fp_cell #(
   parameter int WORD_BITS = 32,
   parameter int DVD_BITS  = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  q16fp_pkg::ctrl_type        ctrl_i,
   input  logic [WORD_BITS-1:0]       rem_i,
   input  logic [DVD_BITS-1:0]        dvd_i,
   input  logic [WORD_BITS-1:0]       quo_i,
   input  logic [WORD_BITS-1:0]       dsr_i,
   input  logic [2*WORD_BITS-1:0]     aux_i,
   output q16fp_pkg::ctrl_type        ctrl_o,
   output logic [WORD_BITS-1:0]       rem_o,
   output logic [DVD_BITS-1:0]        dvd_o,
   output logic [WORD_BITS-1:0]       quo_o,
   output logic [WORD_BITS-1:0]       dsr_o,
   output logic [2*WORD_BITS-1:0]     aux_o
);
   import q16fp_pkg::*;

   ctrl_type               ctrl_ff;
   logic [WORD_BITS-1:0]   rem_ff, rem_in, quo_ff, quo_in, dsr_ff;
   logic [DVD_BITS-1:0]    dvd_ff, dvd_in;
   logic [2*WORD_BITS-1:0] aux_ff;
   logic [WORD_BITS:0]     trial;
   logic                   qbit;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_i, dvd_i[DVD_BITS-1]};
      qbit   = (trial >= {1'b0, dsr_i});
      rem_in = qbit ? WORD_BITS'(trial - {1'b0, dsr_i}) : trial[WORD_BITS-1:0];
      quo_in = {quo_i[WORD_BITS-2:0], qbit};
      dvd_in = {dvd_i[DVD_BITS-2:0], 1'b0};
   end

   // clear the control under reset, advance it with the word
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_i;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff       <= rem_in;
         quo_ff       <= quo_in;
         dvd_ff       <= dvd_in;
         dsr_ff       <= dsr_i;
         aux_ff       <= aux_i;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign rem_o  = rem_ff;
   assign dvd_o  = dvd_ff;
   assign quo_o  = quo_ff;
   assign dsr_o  = dsr_ff;
   assign aux_o  = aux_ff;

endmodule

// ===== rtl/q16_fixed_point_alu.sv =====
// Signed fixed-point arithmetic unit (Q16.16 by default): multiply, divide,
// float-to-fixed conversion and absolute value, one result word per request
// word. The unit is fully pipelined and takes a new word every cycle while the
// output side keeps up. Each word passes an entry register, then the chain of
// restoring-division cells, one quotient bit per cell, then an output register;
// every operation travels the same chain so results leave in request order.
// A stall on rsp_tready freezes the whole chain.
module q16_fixed_point_alu #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] operand_a, [63:32] operand_b, [95:64] float_bits
   input  logic [95:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] result
   output logic [31:0] rsp_tdata,
   // [1:0] error
   output logic [1:0]  rsp_tuser
);
   import q16fp_pkg::*;

   localparam int NCELL = WORD_BITS + FRAC_BITS;
   localparam int W = WORD_BITS;

   logic advance;

   // entry decode
   func_type            func;
   logic signed [W-1:0] opa, opb;
   logic [31:0]         fbits;
   logic [W-1:0]        mag_a, mag_b, abs_r, f2fx_r;
   logic [7:0]          ex;
   logic [23:0]         mant;
   logic signed [9:0]   sh;
   logic [63:0]         fmag, flim;
   logic                fneg, fovf;
   err_type             err0;
   logic signed [2*W-1:0] prod;
   logic [2*W-1:0]      aux0;

   always_comb begin
      func  = func_type'(req_tuser);
      opa   = req_tdata[W-1:0];
      opb   = req_tdata[32+W-1:32];
      fbits = req_tdata[95:64];
      mag_a = opa[W-1] ? W'(-opa) : opa;
      mag_b = opb[W-1] ? W'(-opb) : opb;
      abs_r = mag_a;
      // full signed product
      prod  = opa * opb;
      // float to fixed, truncate toward zero and saturate
      fneg  = fbits[31];
      ex    = fbits[30:23];
      mant  = {(ex != 8'd0), fbits[MANT_BITS-1:0]};
      sh    = $signed({2'b00, ex}) - 10'(EXP_BIAS_SHIFT) + 10'(FRAC_BITS);
      flim  = (64'd1 << (W-1)) - {63'd0, !fneg};
      fovf  = 1'b0;
      if (sh < 0) begin
         fmag = {40'd0, mant} >> (-sh);
      end else if (sh > 10'sd40) begin
         fmag = flim;
         fovf = 1'b1;
      end else begin
         fmag = {40'd0, mant} << sh;
      end
      if (fmag > flim) begin
         fmag = flim;
         fovf = 1'b1;
      end
      f2fx_r = fneg ? W'(-fmag) : fmag[W-1:0];
      case (func)
         FUNC_MUL:  aux0 = prod;
         FUNC_F2FX: aux0 = {{W{1'b0}}, f2fx_r};
         default:   aux0 = {{W{1'b0}}, abs_r};
      endcase
      case (func)
         FUNC_DIV:  err0 = (mag_b == '0) ? ERR_DIVZ : ERR_NONE;
         FUNC_F2FX: err0 = fovf ? ERR_OVF : ERR_NONE;
         default:   err0 = ERR_NONE;
      endcase
   end

   // chain taps
   ctrl_type [NCELL:0]                ctrl_c;
   logic     [NCELL:0][W-1:0]         rem_c, quo_c, dsr_c;
   logic     [NCELL:0][NCELL-1:0]     dvd_c;
   logic     [NCELL:0][2*W-1:0]       aux_c;

   // entry register
   ctrl_type        ctrl0_ff;
   logic [W-1:0]    dsr0_ff;
   logic [NCELL-1:0] dvd0_ff;
   logic [2*W-1:0]  aux0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
      end else if (advance) begin
         ctrl0_ff <= '{valid: req_tvalid, func: func,
                       neg: opa[W-1] ^ opb[W-1], err: err0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dsr0_ff       <= mag_b;
         dvd0_ff       <= {mag_a, {FRAC_BITS{1'b0}}};
         aux0_ff       <= aux0;
      end
   end

   assign ctrl_c[0] = ctrl0_ff;
   assign rem_c[0]  = '0;
   assign quo_c[0]  = '0;
   assign dsr_c[0]  = dsr0_ff;
   assign dvd_c[0]  = dvd0_ff;
   assign aux_c[0]  = aux0_ff;

   // one quotient bit per cell
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      q16fp_cell #(.WORD_BITS(W), .DVD_BITS(NCELL)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctrl_i  (ctrl_c[i]),
         .rem_i   (rem_c[i]),
         .dvd_i   (dvd_c[i]),
         .quo_i   (quo_c[i]),
         .dsr_i   (dsr_c[i]),
         .aux_i   (aux_c[i]),
         .ctrl_o  (ctrl_c[i+1]),
         .rem_o   (rem_c[i+1]),
         .dvd_o   (dvd_c[i+1]),
         .quo_o   (quo_c[i+1]),
         .dsr_o   (dsr_c[i+1]),
         .aux_o   (aux_c[i+1])
      );
   end

   // select the final word, apply sign and widen
   ctrl_type             last;
   logic signed [W-1:0]  res_w;
   logic [31:0]          res_in, res_ff;
   err_type              err_ff;
   logic                 out_valid_ff;

   always_comb begin
      last = ctrl_c[NCELL];
      case (last.func)
         FUNC_MUL: res_w = aux_c[NCELL][FRAC_BITS+W-1:FRAC_BITS];
         FUNC_DIV: begin
            if (last.err == ERR_DIVZ) res_w = '0;
            else if (last.neg)        res_w = W'(-quo_c[NCELL]);
            else                      res_w = quo_c[NCELL];
         end
         default:  res_w = aux_c[NCELL][W-1:0];
      endcase
      res_in = 32'(res_w);
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
         err_ff <= last.err;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = res_ff;
   assign rsp_tuser  = err_ff;

   // divide by zero always yields zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ERR_DIVZ |-> rsp_tdata == 32'd0)
      else $error("divide by zero result not zero");

   // the chain only moves when the output word can leave
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("chain advance mismatch");

   // a stalled output word keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("output word changed while stalled");

endmodule
